/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    logic  enq;
    logic  deq;
    data_t val;
  } cell_ctrl_t;

endpackage

/* hw/rtl/spq_if.sv */
// Request and response channel interfaces for the sorted priority queue.
interface spq_in_if import spq_pkg::*;;
  logic  valid;
  logic  ready;
  op_t   op;
  data_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
  logic  valid;
  logic  ready;
  data_t front_value;
  logic  empty_res;
  cnt_t  count;
  logic  underflow;
  logic  overflow;

  modport source (output valid, output front_value, output empty_res, output count,
                  output underflow, output overflow, input ready);
  modport sink   (input valid, input front_value, input empty_res, input count,
                  input underflow, input overflow, output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// One slot of the sorted chain: compare, hold, take new value or shift.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_less,
  input  data_t      left_data,
  input  data_t      right_data,
  output logic       less,
  output data_t      data,
  output data_t      data_next
);

  logic take_new;

  assign less     = occupied && (data < ctrl.val);
  assign take_new = !less && left_less;

  always_comb begin
    data_next = data;
    if (ctrl.enq) begin
      if (take_new) begin
        data_next = ctrl.val;
      end else if (!less) begin
        data_next = left_data;
      end
    end else if (ctrl.deq) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* hw/rtl/sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: cell chain, count and result register.
//
//   channel | dir | fields                                            | transaction
//   req     | in  | op, value                                         | valid && ready
//   rsp     | out | front_value, empty_res, count, underflow, overflow | valid && ready
//
// One transaction per cycle while rsp.ready is high: all cells compare against the new
// value in parallel and shift or load in the same cycle as the result register loads.
// Reset clears the entry count and the result valid; slot contents are not reset.
// req.ready drops only while a result sits unclaimed with rsp.ready low.
module sorted_priority_queue_unit import spq_pkg::*; (
  input logic       clk,
  input logic       rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);

  cnt_t       entry_count;
  cnt_t       count_next;
  cell_ctrl_t ctrl;
  logic       take;
  logic       is_full;
  logic       is_empty;
  logic       under_next;
  logic       over_next;

  logic  cell_less [DEPTH];
  data_t cell_data [DEPTH];
  data_t cell_next [DEPTH];

  logic  out_valid;
  data_t out_front;
  logic  out_empty;
  cnt_t  out_count;
  logic  out_under;
  logic  out_over;

  assign take     = req.valid && req.ready;
  assign is_full  = entry_count == cnt_t'(DEPTH);
  assign is_empty = entry_count == '0;

  assign ctrl.enq = take && (req.op == OP_ENQ) && !is_full;
  assign ctrl.deq = take && (req.op == OP_DEQ) && !is_empty;
  assign ctrl.val = req.value;

  assign under_next = (req.op == OP_DEQ) && is_empty;
  assign over_next  = (req.op == OP_ENQ) && is_full;

  always_comb begin
    count_next = entry_count;
    if (ctrl.enq) begin
      count_next = entry_count + cnt_t'(1);
    end else if (ctrl.deq) begin
      count_next = entry_count - cnt_t'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  left_less;
    data_t left_data;
    data_t right_data;

    if (i == 0) begin : g_head
      assign left_less = 1'b1;
      assign left_data = ctrl.val;
    end else begin : g_body
      assign left_less = cell_less[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (cnt_t'(i) < entry_count),
      .left_less  (left_less),
      .left_data  (left_data),
      .right_data (right_data),
      .less       (cell_less[i]),
      .data       (cell_data[i]),
      .data_next  (cell_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_front <= (count_next == '0) ? '0 : cell_next[0];
      out_empty <= count_next == '0;
      out_count <= count_next;
      out_under <= under_next;
      out_over  <= over_next;
    end
  end

  assign req.ready       = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.front_value = out_front;
  assign rsp.empty_res   = out_empty;
  assign rsp.count       = out_count;
  assign rsp.underflow   = out_under;
  assign rsp.overflow    = out_over;

endmodule

/* hw/rtl/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker import spq_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  rsp_valid,
  input logic  rsp_ready,
  input data_t rsp_front_value,
  input logic  rsp_empty_res,
  input cnt_t  rsp_count,
  input logic  rsp_underflow,
  input logic  rsp_overflow
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_empty_res == (rsp_count == '0)))
    else $error("empty flag disagrees with count");

  a_under: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_underflow |-> rsp_count == '0 && rsp_front_value == '0 && !rsp_overflow)
    else $error("underflow with entries present");

  a_over: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_overflow |-> rsp_count == cnt_t'(DEPTH))
    else $error("overflow while not full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= cnt_t'(DEPTH))
    else $error("count beyond depth");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_front_value (rsp.front_value),
  .rsp_empty_res   (rsp.empty_res),
  .rsp_count       (rsp.count),
  .rsp_underflow   (rsp.underflow),
  .rsp_overflow    (rsp.overflow)
);
